// ----- rtl/core/pts_pkg.sv -----
// Shared types, codes and helper functions for the planning task supervisor.
`timescale 1ns / 1ps

package pts_pkg;

    // Event codes
    localparam logic [1:0] OP_TASK   = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_PROC   = 2'd2;
    localparam logic [1:0] OP_TIME   = 2'd3;

    // Task command codes; 1..5 double as emitted command kinds
    localparam logic [2:0] CMD_NONE        = 3'd0;
    localparam logic [2:0] CMD_TAKEOFF     = 3'd1;
    localparam logic [2:0] CMD_LAND        = 3'd2;
    localparam logic [2:0] CMD_RETURN      = 3'd3;
    localparam logic [2:0] CMD_KILL        = 3'd4;
    localparam logic [2:0] CMD_HOVER       = 3'd5;
    localparam logic [2:0] CMD_LOCAL_GOAL  = 3'd6;
    localparam logic [2:0] CMD_GLOBAL_GOAL = 3'd7;

    localparam logic [2:0] KIND_TRAJ  = 3'd0;
    localparam logic [2:0] KIND_HOVER = 3'd5;

    // Flight-state report codes
    localparam logic [3:0] FS_OFF     = 4'd0;
    localparam logic [3:0] FS_INIT    = 4'd1;
    localparam logic [3:0] FS_TAKEOFF = 4'd2;
    localparam logic [3:0] FS_HOVER   = 4'd3;
    localparam logic [3:0] FS_RETURN  = 4'd4;
    localparam logic [3:0] FS_LAND    = 4'd5;
    localparam logic [3:0] FS_MOVE    = 4'd6;
    localparam logic [3:0] FS_KILL    = 4'd7;

    // Local state codes
    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_READY    = 4'd1;
    localparam logic [3:0] ST_PLANNING = 4'd2;
    localparam logic [3:0] ST_ARRIVED  = 4'd3;
    localparam logic [3:0] ST_HOVER    = 4'd4;
    localparam logic [3:0] ST_TAKEOFF  = 4'd5;
    localparam logic [3:0] ST_LAND     = 4'd6;
    localparam logic [3:0] ST_RETURN   = 4'd7;
    localparam logic [3:0] ST_KILL     = 4'd8;
    localparam logic [3:0] ST_MOVE     = 4'd9;

    // Planner result codes
    localparam logic [1:0] PR_RUNNING = 2'd0;
    localparam logic [1:0] PR_SUCCESS = 2'd1;

    // Reject reasons
    localparam logic [3:0] RSN_NONE        = 4'd0;
    localparam logic [3:0] RSN_UNSUPPORTED = 4'd1;
    localparam logic [3:0] RSN_STALE       = 4'd2;
    localparam logic [3:0] RSN_NOT_READY   = 4'd3;
    localparam logic [3:0] RSN_TAKEOFF     = 4'd4;
    localparam logic [3:0] RSN_RETURN      = 4'd5;
    localparam logic [3:0] RSN_LAND        = 4'd6;
    localparam logic [3:0] RSN_KILL        = 4'd7;
    localparam logic [3:0] RSN_UNKNOWN     = 4'd8;
    localparam logic [3:0] RSN_GLOBAL      = 4'd9;
    localparam logic [3:0] RSN_NO_WAYPOINT = 4'd10;

    // Task flag bits
    localparam logic [2:0] FLAG_ACTIVE  = 3'b001;
    localparam logic [2:0] FLAG_ARRIVED = 3'b010;
    localparam logic [2:0] FLAG_HOVER   = 3'b100;

    localparam logic [1:0] DEFAULT_SOURCE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FOLLOW  = 2'd0;
    localparam logic [1:0] REG_HOVER   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_GRACE   = 2'd3;

    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [15:0] GRACE_RESET    = 16'd2000;
    localparam logic [15:0] TIMEOUT_ZERO   = 16'd1000;

    typedef struct packed {
        logic       follow_control_state;
        logic       hover_on_output_timeout;
        logic [15:0] state_timeout_ticks;
        logic [15:0] handshake_grace_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] command;
        logic [7:0] wp_count;
        logic [1:0] command_source;
        logic       goal_accepted;
        logic [3:0] flight_state;
        logic       on_trajectory;
        logic       planner_ready;
        logic [1:0] planner_result;
        logic       output_stale;
        logic       position_ready;
    } item_t;

    typedef struct packed {
        logic [3:0]  local_state;
        logic [3:0]  eff_state;
        logic        emit_command;
        logic [2:0]  emitted_kind;
        logic [1:0]  emitted_source;
        logic [15:0] task_number;
        logic [2:0]  context_flags;
        logic [3:0]  reject_code;
    } result_t;

    function automatic logic [3:0] kind_to_state(input logic [2:0] kind);
        logic [3:0] st;
        case (kind)
            CMD_TAKEOFF: st = ST_TAKEOFF;
            CMD_LAND:    st = ST_LAND;
            CMD_RETURN:  st = ST_RETURN;
            CMD_KILL:    st = ST_KILL;
            CMD_HOVER:   st = ST_HOVER;
            default:     st = ST_READY;
        endcase
        return st;
    endfunction

    function automatic logic report_fresh(input logic have, input logic [31:0] now,
                                          input logic [31:0] stamp,
                                          input logic [15:0] limit);
        logic [31:0] age;
        age = now - stamp;
        return have && (age <= {16'd0, limit});
    endfunction

endpackage

// ----- rtl/core/pts_cfg_regs.sv -----
// Configuration register file with write-only port.
`timescale 1ns / 1ps

module pts_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pts_pkg::cfg_t                  cfg
);

    pts_pkg::cfg_t cfg_reg;
    pts_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                pts_pkg::REG_FOLLOW:  cfg_next.follow_control_state    = cfg_wdata[0];
                pts_pkg::REG_HOVER:   cfg_next.hover_on_output_timeout = cfg_wdata[0];
                pts_pkg::REG_TIMEOUT: cfg_next.state_timeout_ticks     = cfg_wdata[15:0];
                pts_pkg::REG_GRACE:   cfg_next.handshake_grace_ticks   = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.follow_control_state    <= 1'b1;
            cfg_reg.hover_on_output_timeout <= 1'b1;
            cfg_reg.state_timeout_ticks     <= pts_pkg::TIMEOUT_RESET;
            cfg_reg.handshake_grace_ticks   <= pts_pkg::GRACE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/pts_in_reg.sv -----
// Input pipeline register for event beats.
`timescale 1ns / 1ps

module pts_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pts_pkg::item_t s_item,
    output logic           item_valid,
    input  logic           item_ready,
    output pts_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    pts_pkg::item_t item_reg;

    assign s_ready = !valid_reg || item_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/pts_core.sv -----
// Task supervisor state and single-pass event decision logic.
`timescale 1ns / 1ps

module pts_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  pts_pkg::cfg_t    cfg,
    input  logic             item_valid,
    output logic             item_ready,
    input  pts_pkg::item_t   item,
    output logic             res_valid,
    input  logic             res_ready,
    output pts_pkg::result_t res
);

    typedef struct packed {
        logic [31:0] time_now;
        logic [31:0] report_stamp;
        logic        have_report;
        logic [3:0]  last_flight_state;
        logic        last_on_trajectory;
        logic [31:0] accept_stamp;
        logic        trajectory_ack;
        logic [2:0]  task_flags;
        logic [2:0]  pending_command;
        logic        have_task;
        logic        task_is_goal;
        logic [1:0]  task_source;
        logic [15:0] task_counter;
        logic [3:0]  mode_state;
    } sup_state_t;

    sup_state_t  st_reg;
    sup_state_t  st_next;
    logic        fire;
    logic [15:0] limit;
    logic        fresh_cur;
    logic        fresh_new;
    logic [3:0]  gate;
    logic [2:0]  norm;
    logic [31:0] accept_age;
    logic        grace_ok;
    logic [3:0]  reason;
    logic        emit;
    logic [2:0]  kind;
    logic [1:0]  src;
    logic [3:0]  eff;

    assign fire       = item_valid && res_ready;
    assign item_ready = res_ready;
    assign res_valid  = item_valid;

    assign limit = (cfg.state_timeout_ticks == 16'd0) ? pts_pkg::TIMEOUT_ZERO
                                                      : cfg.state_timeout_ticks;
    assign fresh_cur = pts_pkg::report_fresh(st_reg.have_report, st_reg.time_now,
                                             st_reg.report_stamp, limit);
    assign fresh_new = pts_pkg::report_fresh(st_next.have_report, st_next.time_now,
                                             st_next.report_stamp, limit);
    assign accept_age = st_reg.time_now - st_reg.accept_stamp;
    assign grace_ok   = accept_age <= {16'd0, cfg.handshake_grace_ticks};

    // goal gate from the last report
    always_comb begin
        gate = pts_pkg::RSN_NONE;
        if (cfg.follow_control_state) begin
            if (!fresh_cur) begin
                gate = pts_pkg::RSN_STALE;
            end else begin
                case (st_reg.last_flight_state) inside
                    pts_pkg::FS_HOVER, pts_pkg::FS_MOVE: gate = pts_pkg::RSN_NONE;
                    pts_pkg::FS_OFF, pts_pkg::FS_INIT:   gate = pts_pkg::RSN_NOT_READY;
                    pts_pkg::FS_TAKEOFF:                 gate = pts_pkg::RSN_TAKEOFF;
                    pts_pkg::FS_RETURN:                  gate = pts_pkg::RSN_RETURN;
                    pts_pkg::FS_LAND:                    gate = pts_pkg::RSN_LAND;
                    pts_pkg::FS_KILL:                    gate = pts_pkg::RSN_KILL;
                    default:                             gate = pts_pkg::RSN_UNKNOWN;
                endcase
            end
        end
    end

    always_comb begin
        norm = item.command;
        if (item.command == pts_pkg::CMD_NONE && item.wp_count != 8'd0) begin
            norm = pts_pkg::CMD_LOCAL_GOAL;
        end
    end

    always_comb begin
        st_next = st_reg;
        reason  = pts_pkg::RSN_NONE;
        emit    = 1'b0;
        kind    = pts_pkg::KIND_TRAJ;
        case (item.operation)
            pts_pkg::OP_TASK: begin
                st_next.have_task    = 1'b1;
                st_next.task_is_goal = (norm == pts_pkg::CMD_LOCAL_GOAL) ||
                                       (norm == pts_pkg::CMD_GLOBAL_GOAL);
                st_next.task_source  = item.command_source;
                st_next.task_counter = st_reg.task_counter + 16'd1;
                st_next.task_flags   = st_reg.task_flags &
                                       ~(pts_pkg::FLAG_ARRIVED | pts_pkg::FLAG_HOVER);
                if (norm >= pts_pkg::CMD_TAKEOFF && norm <= pts_pkg::CMD_HOVER) begin
                    st_next.pending_command = norm;
                    st_next.task_flags = (norm == pts_pkg::CMD_HOVER) ? pts_pkg::FLAG_HOVER
                                                                      : 3'b000;
                    st_next.mode_state = pts_pkg::kind_to_state(norm);
                end else begin
                    st_next.pending_command = pts_pkg::CMD_NONE;
                    if (norm == pts_pkg::CMD_NONE) begin
                        st_next.task_flags = st_next.task_flags & ~pts_pkg::FLAG_ACTIVE;
                        st_next.mode_state = pts_pkg::ST_READY;
                        reason = pts_pkg::RSN_UNSUPPORTED;
                    end else if (gate != pts_pkg::RSN_NONE) begin
                        st_next.task_flags = st_next.task_flags & ~pts_pkg::FLAG_ACTIVE;
                        reason = gate;
                    end else if (norm == pts_pkg::CMD_GLOBAL_GOAL) begin
                        st_next.task_flags = st_next.task_flags & ~pts_pkg::FLAG_ACTIVE;
                        st_next.mode_state = pts_pkg::ST_READY;
                        reason = pts_pkg::RSN_GLOBAL;
                    end else if (item.wp_count == 8'd0) begin
                        st_next.task_flags = st_next.task_flags & ~pts_pkg::FLAG_ACTIVE;
                        st_next.mode_state = pts_pkg::ST_READY;
                        reason = pts_pkg::RSN_NO_WAYPOINT;
                    end else if (!item.goal_accepted) begin
                        st_next.task_flags      = pts_pkg::FLAG_HOVER;
                        st_next.pending_command = pts_pkg::KIND_HOVER;
                        st_next.mode_state      = pts_pkg::ST_HOVER;
                    end else begin
                        st_next.task_flags     = pts_pkg::FLAG_ACTIVE;
                        st_next.trajectory_ack = 1'b0;
                        st_next.accept_stamp   = st_reg.time_now;
                        st_next.mode_state     = pts_pkg::ST_PLANNING;
                    end
                end
            end
            pts_pkg::OP_REPORT: begin
                st_next.last_flight_state  = item.flight_state;
                st_next.last_on_trajectory = item.on_trajectory;
                st_next.report_stamp       = st_reg.time_now;
                st_next.have_report        = 1'b1;
                if (cfg.follow_control_state) begin
                    if (st_reg.task_flags[0] && item.flight_state == pts_pkg::FS_MOVE &&
                        item.on_trajectory) begin
                        st_next.trajectory_ack = 1'b1;
                    end else if (st_reg.task_flags[1] &&
                                 item.flight_state == pts_pkg::FS_HOVER) begin
                        st_next.task_flags = st_reg.task_flags;
                    end else if (st_reg.task_flags[0] && !st_reg.trajectory_ack &&
                                 grace_ok && item.flight_state == pts_pkg::FS_HOVER) begin
                        st_next.task_flags = st_reg.task_flags;
                    end else begin
                        st_next.task_flags = (item.flight_state == pts_pkg::FS_HOVER) ?
                                             pts_pkg::FLAG_HOVER : 3'b000;
                        st_next.pending_command = pts_pkg::CMD_NONE;
                    end
                end
            end
            pts_pkg::OP_PROC: begin
                if (!item.planner_ready) begin
                    st_next.mode_state = pts_pkg::ST_INIT;
                end else begin
                    if (st_reg.task_flags[0]) begin
                        if (item.planner_result == pts_pkg::PR_SUCCESS) begin
                            st_next.task_flags      = pts_pkg::FLAG_ARRIVED;
                            st_next.pending_command = pts_pkg::KIND_HOVER;
                            st_next.mode_state      = pts_pkg::ST_ARRIVED;
                        end else if (item.planner_result != pts_pkg::PR_RUNNING ||
                                     (cfg.hover_on_output_timeout && item.output_stale)) begin
                            st_next.task_flags      = pts_pkg::FLAG_HOVER;
                            st_next.pending_command = pts_pkg::KIND_HOVER;
                            st_next.mode_state      = pts_pkg::ST_HOVER;
                        end else begin
                            st_next.mode_state = pts_pkg::ST_PLANNING;
                        end
                    end else if (st_reg.pending_command != pts_pkg::CMD_NONE) begin
                        st_next.mode_state = pts_pkg::kind_to_state(st_reg.pending_command);
                    end else if (st_reg.task_flags[1]) begin
                        st_next.mode_state = pts_pkg::ST_ARRIVED;
                    end else if (st_reg.task_flags[2]) begin
                        st_next.mode_state = pts_pkg::ST_HOVER;
                    end else begin
                        st_next.mode_state = pts_pkg::ST_READY;
                    end
                    // emission looks at the flags just updated
                    if (st_next.task_flags[0]) begin
                        if (item.position_ready) begin
                            emit = 1'b1;
                            kind = pts_pkg::KIND_TRAJ;
                        end
                    end else if (st_next.pending_command != pts_pkg::CMD_NONE) begin
                        emit = 1'b1;
                        kind = st_next.pending_command;
                        st_next.pending_command = pts_pkg::CMD_NONE;
                    end
                end
            end
            default: begin
                st_next.time_now = st_reg.time_now + 32'd1;
            end
        endcase
    end

    always_comb begin
        src = 2'd0;
        if (emit) begin
            src = st_next.have_task ? st_next.task_source : pts_pkg::DEFAULT_SOURCE;
        end
    end

    // effective state from the updated state
    always_comb begin
        eff = st_next.mode_state;
        if (cfg.follow_control_state && fresh_new) begin
            case (st_next.last_flight_state) inside
                pts_pkg::FS_OFF, pts_pkg::FS_INIT: eff = pts_pkg::ST_INIT;
                pts_pkg::FS_TAKEOFF:               eff = pts_pkg::ST_TAKEOFF;
                pts_pkg::FS_HOVER:
                    eff = st_next.task_flags[1] ? pts_pkg::ST_ARRIVED : pts_pkg::ST_HOVER;
                pts_pkg::FS_RETURN:                eff = pts_pkg::ST_RETURN;
                pts_pkg::FS_LAND:                  eff = pts_pkg::ST_LAND;
                pts_pkg::FS_MOVE:
                    eff = (st_next.task_flags[0] && st_next.have_task &&
                           st_next.task_is_goal && st_next.last_on_trajectory) ?
                          pts_pkg::ST_PLANNING : pts_pkg::ST_MOVE;
                pts_pkg::FS_KILL:                  eff = pts_pkg::ST_KILL;
                default:                           eff = st_next.mode_state;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    assign res.local_state     = st_next.mode_state;
    assign res.eff_state       = eff;
    assign res.emit_command    = emit;
    assign res.emitted_kind    = kind;
    assign res.emitted_source  = src;
    assign res.task_number     = st_next.task_counter;
    assign res.context_flags   = st_next.task_flags;
    assign res.reject_code     = reason;

`ifndef ASSERT_OFF
    a_task_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == pts_pkg::OP_TASK |=>
        st_reg.task_counter == $past(st_reg.task_counter) + 16'd1)
        else $error("task counter did not advance on a task command");

    a_emit_on_proc: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation != pts_pkg::OP_PROC |-> !res.emit_command)
        else $error("command emitted outside a process tick");

    a_oneshot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.emit_command && res.emitted_kind != pts_pkg::KIND_TRAJ |=>
        st_reg.pending_command == pts_pkg::CMD_NONE)
        else $error("one-shot command still pending after emission");

    a_time_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && item.operation == pts_pkg::OP_TIME) |=> $stable(st_reg.time_now))
        else $error("time moved without a time tick");

    a_active_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.task_flags[0] |-> st_reg.pending_command == pts_pkg::CMD_NONE)
        else $error("one-shot command pending during an active goal");
`endif

endmodule

// ----- rtl/core/pts_out_reg.sv -----
// Output register for result beats.
`timescale 1ns / 1ps

module pts_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  pts_pkg::result_t res,
    output logic             m_valid,
    input  logic             m_ready,
    output pts_pkg::result_t m_res
);

    logic             valid_reg;
    logic             valid_next;
    pts_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid && res_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ----- rtl/core/planning_task_supervisor_top.sv -----
// Top level of the planning task supervisor.
`timescale 1ns / 1ps

// Supervises a vehicle goal task from a stream of event beats (task command,
// flight-state report, planner process tick, 1 ms time tick) and returns one
// result beat per event. Throughput is one event per clock cycle while m_ready
// is held high; an accepted beat lands in the input register, is decided by
// pts_core from that register, and its result is registered in the output
// register. The rate is set by the state update in pts_core, which reads and
// writes all supervisor state for each event. Configuration writes take effect
// at the next clock edge; the user must make them only while no beat is in
// flight, and the block itself does not enforce this.

module planning_task_supervisor_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [2:0]                     s_command,
    input  logic [7:0]                     s_wp_count,
    input  logic [1:0]                     s_command_source,
    input  logic                           s_goal_accepted,
    input  logic [3:0]                     s_flight_state,
    input  logic                           s_on_trajectory,
    input  logic                           s_planner_ready,
    input  logic [1:0]                     s_planner_result,
    input  logic                           s_output_stale,
    input  logic                           s_position_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_local_state,
    output logic [3:0]                     m_eff_state,
    output logic                           m_emit_command,
    output logic [2:0]                     m_emitted_kind,
    output logic [1:0]                     m_emitted_source,
    output logic [15:0]                    m_task_number,
    output logic [2:0]                     m_context_flags,
    output logic [3:0]                     m_reject_code
);

    pts_pkg::cfg_t    cfg;
    pts_pkg::item_t   s_item;
    pts_pkg::item_t   item;
    logic             item_valid;
    logic             item_ready;
    pts_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;
    pts_pkg::result_t m_res;

    assign s_item.operation      = s_operation;
    assign s_item.command        = s_command;
    assign s_item.wp_count       = s_wp_count;
    assign s_item.command_source = s_command_source;
    assign s_item.goal_accepted  = s_goal_accepted;
    assign s_item.flight_state   = s_flight_state;
    assign s_item.on_trajectory  = s_on_trajectory;
    assign s_item.planner_ready  = s_planner_ready;
    assign s_item.planner_result = s_planner_result;
    assign s_item.output_stale   = s_output_stale;
    assign s_item.position_ready = s_position_ready;

    pts_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pts_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    pts_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    pts_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_local_state     = m_res.local_state;
    assign m_eff_state       = m_res.eff_state;
    assign m_emit_command    = m_res.emit_command;
    assign m_emitted_kind    = m_res.emitted_kind;
    assign m_emitted_source  = m_res.emitted_source;
    assign m_task_number     = m_res.task_number;
    assign m_context_flags   = m_res.context_flags;
    assign m_reject_code     = m_res.reject_code;

endmodule
